FILE: rtl/bgpg_pkg.sv
// Package for the bitmap glyph pixel generator: glyph ROM, register map,
// saturation limit and shared types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bgpg_pkg;

    localparam int unsigned   GLYPH_ROWS = 5;
    localparam int unsigned   GLYPH_COLS = 5;
    localparam int unsigned   GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;
    localparam logic [11:0]   WIDTH_MAX  = 12'hFFF;
    localparam logic [7:0]    CODE_DEGREE = 8'hB0;

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_ORIGIN_X     = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y     = 2'd1;
    localparam logic [1:0] REG_DRAW_COLOR   = 2'd2;
    localparam logic [1:0] REG_MEASURE_ONLY = 2'd3;

    // rows top first, row 0 in the top bits; each row left-aligned in 5 bits
    typedef struct packed {
        logic                  valid;
        logic [2:0]            w;
        logic [GLYPH_BITS-1:0] bits;
    } t_glyph;

    function automatic logic [4:0] align_row(input logic [4:0] r, input logic [2:0] w);
        logic [2:0] pad;
        pad = 3'd5 - w;
        return r << pad;
    endfunction

    function automatic t_glyph mk_glyph(input logic [2:0] w,
                                        input logic [4:0] r0, input logic [4:0] r1,
                                        input logic [4:0] r2, input logic [4:0] r3,
                                        input logic [4:0] r4);
        t_glyph g;
        g.valid = 1'b1;
        g.w     = w;
        g.bits  = {align_row(r0, w), align_row(r1, w), align_row(r2, w),
                   align_row(r3, w), align_row(r4, w)};
        return g;
    endfunction

    function automatic t_glyph glyph_rom(input logic [7:0] c);
        t_glyph g;
        g = '0;
        case (c) inside
            8'h30:              g = mk_glyph(3'd3, 5'd7, 5'd5, 5'd5, 5'd5, 5'd7);
            8'h31:              g = mk_glyph(3'd3, 5'd2, 5'd6, 5'd2, 5'd2, 5'd7);
            8'h32:              g = mk_glyph(3'd3, 5'd7, 5'd1, 5'd7, 5'd4, 5'd7);
            8'h33:              g = mk_glyph(3'd3, 5'd7, 5'd1, 5'd7, 5'd1, 5'd7);
            8'h34:              g = mk_glyph(3'd3, 5'd5, 5'd5, 5'd7, 5'd1, 5'd1);
            8'h35:              g = mk_glyph(3'd3, 5'd7, 5'd4, 5'd7, 5'd1, 5'd7);
            8'h36:              g = mk_glyph(3'd3, 5'd7, 5'd4, 5'd7, 5'd5, 5'd7);
            8'h37:              g = mk_glyph(3'd3, 5'd7, 5'd1, 5'd1, 5'd1, 5'd1);
            8'h38:              g = mk_glyph(3'd3, 5'd7, 5'd5, 5'd7, 5'd5, 5'd7);
            8'h39:              g = mk_glyph(3'd3, 5'd7, 5'd5, 5'd7, 5'd1, 5'd7);
            8'h3A:              g = mk_glyph(3'd1, 5'd0, 5'd1, 5'd0, 5'd1, 5'd0);
            8'h20:              g = mk_glyph(3'd2, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
            8'h2D:              g = mk_glyph(3'd3, 5'd0, 5'd0, 5'd7, 5'd0, 5'd0);
            8'h2E:              g = mk_glyph(3'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1);
            CODE_DEGREE, 8'h2A: g = mk_glyph(3'd3, 5'd2, 5'd5, 5'd2, 5'd0, 5'd0);
            8'h55, 8'h75:       g = mk_glyph(3'd3, 5'd5, 5'd5, 5'd5, 5'd5, 5'd7);
            8'h56, 8'h76:       g = mk_glyph(3'd3, 5'd5, 5'd5, 5'd5, 5'd2, 5'd2);
            8'h46, 8'h66:       g = mk_glyph(3'd3, 5'd7, 5'd4, 5'd6, 5'd4, 5'd4);
            8'h41, 8'h61:       g = mk_glyph(3'd3, 5'd7, 5'd5, 5'd7, 5'd5, 5'd5);
            8'h50, 8'h70:       g = mk_glyph(3'd3, 5'd7, 5'd5, 5'd7, 5'd4, 5'd4);
            8'h4D, 8'h6D:       g = mk_glyph(3'd5, 5'h11, 5'h1B, 5'h15, 5'h11, 5'h11);
            default:            g = '0;
        endcase
        return g;
    endfunction

    // 12-bit add that clamps at the width limit
    function automatic logic [11:0] sat_add(input logic [11:0] a, input logic [2:0] b);
        logic [12:0] s;
        s = {1'b0, a} + {10'd0, b};
        return s[12] ? WIDTH_MAX : s[11:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bitmap_glyph_pixel_generator_top.sv
// Bitmap glyph pixel generator, top level: config registers, glyph scanner
// and output register. Depends on bgpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Handshake             | Payload
// ----------+-----+-----------------------+------------------------------------------
// s (char)  | in  | i_s_tvalid/o_s_tready | tdata: char_code; tuser: start_of_string
// m (pixel) | out | o_m_tvalid/i_m_tready | tdata: x,y,color,width; tuser: is_pixel;
//           |     |                       | tlast: end of character
// apb       | in  | psel/penable/pready   | 4 registers at byte offsets 0,4,8,12
//
// A supported glyph of width w goes through lookup, prep, a scan of all 5*w
// cells and a status request, one bit of the glyph shift register per cycle
// while the output is not stalled. Measure-only characters skip the scan and
// unsupported ones skip prep and scan. Reset (synchronous, active low) clears
// the running width, sets the first-glyph flag and restores register defaults.
// A stalled output holds the scanner in place; one new character is taken
// whenever the scanner is idle, even while the last status request waits.
module bitmap_glyph_pixel_generator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // character stream
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  wire logic        i_s_tuser,   // [0] start_of_string
    // pixel stream
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [63:0] o_m_tdata,   // [13:0] pixel_x, [26:14] pixel_y,
                                          // [50:27] pixel_color, [62:51] width_so_far
    output      logic        o_m_tuser,   // [0] is_pixel
    output      logic        o_m_tlast,   // end of character
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_PREP   = 5'b00100,
        S_SCAN   = 5'b01000,
        S_STATUS = 5'b10000
    } t_state;

    // ---------------- configuration registers ----------------
    logic [11:0] r_origin_x, r_origin_y;
    logic [23:0] r_draw_color;
    logic        r_measure_only;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_draw_color   <= 24'hFFFFFF;
            r_measure_only <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                bgpg_pkg::REG_ORIGIN_X:     r_origin_x     <= pwdata[11:0];
                bgpg_pkg::REG_ORIGIN_Y:     r_origin_y     <= pwdata[11:0];
                bgpg_pkg::REG_DRAW_COLOR:   r_draw_color   <= pwdata[23:0];
                bgpg_pkg::REG_MEASURE_ONLY: r_measure_only <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bgpg_pkg::REG_ORIGIN_X:     prdata = {20'd0, r_origin_x};
            bgpg_pkg::REG_ORIGIN_Y:     prdata = {20'd0, r_origin_y};
            bgpg_pkg::REG_DRAW_COLOR:   prdata = {8'd0, r_draw_color};
            bgpg_pkg::REG_MEASURE_ONLY: prdata = {31'd0, r_measure_only};
            default:                    prdata = '0;
        endcase
    end

    // ---------------- scanner ----------------
    t_state           r_state, n_state;
    logic [7:0]       r_char;
    logic             r_sos;
    bgpg_pkg::t_glyph r_glyph;
    logic [11:0]      r_cursor, n_cursor;
    logic             r_first, n_first;
    logic [11:0]      r_start;
    logic [24:0]      r_shift;     // glyph cells, next cell in the top bit
    logic [4:0]       r_cnt;       // cells left to scan
    logic [2:0]       r_col;
    logic [13:0]      r_base_x;    // x of column 0 of this glyph
    logic [13:0]      r_px;
    logic [12:0]      r_py;

    // output register
    logic        r_ovalid;
    logic [63:0] r_odata;
    logic        r_ouser, r_olast;
    logic        out_free;

    bgpg_pkg::t_glyph lk_glyph;
    logic [11:0]      cur_eff;
    logic             first_eff;
    logic             row_end;
    logic [2:0]       row_skip;

    assign out_free  = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);

    assign lk_glyph  = bgpg_pkg::glyph_rom(r_char);
    assign cur_eff   = r_sos ? 12'd0 : r_cursor;
    assign first_eff = r_sos || r_first;
    assign row_end   = (r_col == r_glyph.w - 3'd1);
    // skip the row's left-alignment padding at the end of a row
    assign row_skip  = 3'd6 - r_glyph.w;

    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_first  = r_first;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                // apply start-of-string even for an unsupported code
                n_cursor = cur_eff;
                n_first  = first_eff;
                n_state  = lk_glyph.valid ? S_PREP : S_STATUS;
            end
            S_PREP: begin
                n_cursor = bgpg_pkg::sat_add(r_start, r_glyph.w);
                n_first  = 1'b0;
                n_state  = r_measure_only ? S_STATUS : S_SCAN;
            end
            S_SCAN: begin
                if (out_free && r_cnt == 5'd1) begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
            r_first  <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_first  <= n_first;
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    r_char <= i_s_tdata;
                    r_sos  <= i_s_tuser;
                end
            end
            S_LOOKUP: begin
                r_glyph <= lk_glyph;
                r_start <= first_eff ? cur_eff : bgpg_pkg::sat_add(cur_eff, 3'd1);
            end
            S_PREP: begin
                r_shift  <= r_glyph.bits;
                r_cnt    <= {2'b00, r_glyph.w} + {r_glyph.w, 2'b00};
                r_col    <= '0;
                r_base_x <= {{2{r_origin_x[11]}}, r_origin_x} + {2'b00, r_start};
                r_px     <= {{2{r_origin_x[11]}}, r_origin_x} + {2'b00, r_start};
                r_py     <= {r_origin_y[11], r_origin_y};
            end
            S_SCAN: begin
                // advance one cell per cycle while the output can take it
                if (out_free) begin
                    r_cnt <= r_cnt - 5'd1;
                    if (row_end) begin
                        r_shift <= r_shift << row_skip;
                        r_col   <= '0;
                        r_px    <= r_base_x;
                        r_py    <= r_py + 13'd1;
                    end else begin
                        r_shift <= r_shift << 1;
                        r_col   <= r_col + 3'd1;
                        r_px    <= r_px + 14'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // output register: load a pixel request for a lit cell, then the status request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_SCAN && out_free && r_shift[24]) begin
            r_ovalid <= 1'b1;
        end else if (r_state == S_STATUS && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && out_free && r_shift[24]) begin
            r_odata <= {1'b0, r_cursor, r_draw_color, r_py, r_px};
            r_ouser <= 1'b1;
            r_olast <= 1'b0;
        end else if (r_state == S_STATUS && out_free) begin
            r_odata <= {1'b0, r_cursor, 51'd0};
            r_ouser <= 1'b0;
            r_olast <= 1'b1;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

`ifndef SYNTHESIS
    // status request and pixel request are mutually exclusive kinds
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == !o_m_tuser))
        else $error("tlast does not match request kind");

    // status request carries only the width
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[50:0] == 51'd0))
        else $error("status request has nonzero pixel fields");

    // scanner never runs with an empty cell count
    a_scan_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt != 5'd0))
        else $error("scan with no cells left");

    // a prepared glyph always leaves the first-glyph flag clear
    a_first_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |=> !r_first)
        else $error("first-glyph flag not cleared");
`endif

endmodule

`default_nettype wire
